// ===== sv/lrtd_pkg.sv =====
package lrtd_pkg;

  localparam int FIELD_W = 16;

  typedef logic [7:0]         text_byte_t;
  typedef logic [FIELD_W-1:0] field_t;

  // one decoded run of live cells
  typedef struct packed {
    field_t start_x;
    field_t row_y;
    field_t run_length;
  } run_t;

  // characters of the pattern text
  localparam text_byte_t CH_LF   = 8'h0A;
  localparam text_byte_t CH_CR   = 8'h0D;
  localparam text_byte_t CH_BANG = 8'h21;
  localparam text_byte_t CH_HASH = 8'h23;
  localparam text_byte_t CH_DOLL = 8'h24;
  localparam text_byte_t CH_0    = 8'h30;
  localparam text_byte_t CH_9    = 8'h39;
  localparam text_byte_t CH_B    = 8'h62;
  localparam text_byte_t CH_O    = 8'h6F;
  localparam text_byte_t CH_X    = 8'h78;

endpackage

// ===== sv/lrtd_byte_if.sv =====
interface lrtd_byte_if;
  import lrtd_pkg::*;

  logic       valid;
  logic       ready;
  text_byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== sv/lrtd_run_if.sv =====
interface lrtd_run_if;
  import lrtd_pkg::*;

  logic   valid;
  logic   ready;
  field_t start_x;
  field_t row_y;
  field_t run_length;

  modport source (output valid, output start_x, output row_y, output run_length, input ready);
  modport sink   (input valid, input start_x, input row_y, input run_length, output ready);
endinterface

// ===== sv/lrtd_parser.sv =====
module lrtd_parser #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lrtd_pkg::text_byte_t text_byte,
  output logic                emit,
  output lrtd_pkg::run_t      result
);
  import lrtd_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   coord_sum_t;
  typedef logic [COORD_BITS+3:0] coord_wide_t;

  localparam coord_t COORD_MAX = '1;

  coord_t run_value, run_value_next;
  coord_t cursor_x, cursor_x_next;
  coord_t cursor_y, cursor_y_next;
  logic   at_line_start, at_line_start_next;
  logic   skipping_line, skipping_line_next;
  logic   cr_pending, cr_pending_next;
  logic   finished, finished_next;

  coord_t      run_eff;
  coord_t      count;
  coord_wide_t run_times_ten;
  coord_t      digit_run;
  coord_sum_t  x_sum;
  coord_sum_t  y_sum;
  coord_t      x_adv;
  coord_t      y_adv;
  logic        is_digit;
  logic        line_start_eff;

  // a held-back cr clears the run before a byte other than lf is seen
  assign run_eff        = cr_pending ? '0 : run_value;
  assign line_start_eff = at_line_start && !cr_pending;
  assign count          = (run_eff == '0) ? coord_t'(1) : run_eff;
  assign is_digit       = text_byte inside {[CH_0:CH_9]};

  // run * 10 + digit, saturating
  assign run_times_ten = (coord_wide_t'(run_eff) << 3) + (coord_wide_t'(run_eff) << 1)
                       + coord_wide_t'(text_byte[3:0]);
  assign digit_run = (|run_times_ten[COORD_BITS+3:COORD_BITS]) ? COORD_MAX
                   : run_times_ten[COORD_BITS-1:0];

  assign x_sum = coord_sum_t'(cursor_x) + coord_sum_t'(count);
  assign y_sum = coord_sum_t'(cursor_y) + coord_sum_t'(count);
  assign x_adv = x_sum[COORD_BITS] ? COORD_MAX : x_sum[COORD_BITS-1:0];
  assign y_adv = y_sum[COORD_BITS] ? COORD_MAX : y_sum[COORD_BITS-1:0];

  always_comb begin
    run_value_next     = run_value;
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    at_line_start_next = at_line_start;
    skipping_line_next = skipping_line;
    cr_pending_next    = cr_pending;
    finished_next      = finished;
    emit               = 1'b0;
    if (!finished) begin
      if (skipping_line) begin
        if (text_byte == CH_LF) begin
          skipping_line_next = 1'b0;
          at_line_start_next = 1'b1;
        end
      end else if (text_byte == CH_LF) begin
        cr_pending_next    = 1'b0;
        at_line_start_next = 1'b1;
      end else begin
        if (cr_pending) begin
          cr_pending_next    = 1'b0;
          at_line_start_next = 1'b0;
          run_value_next     = '0;
        end
        if (text_byte == CH_CR) begin
          cr_pending_next = 1'b1;
        end else if (line_start_eff && (text_byte == CH_HASH || text_byte == CH_X)) begin
          at_line_start_next = 1'b0;
          skipping_line_next = 1'b1;
        end else begin
          at_line_start_next = 1'b0;
          if (text_byte == CH_BANG) begin
            finished_next = 1'b1;
          end else if (is_digit) begin
            run_value_next = digit_run;
          end else begin
            run_value_next = '0;
            case (text_byte)
              CH_B: begin
                cursor_x_next = x_adv;
              end
              CH_DOLL: begin
                cursor_y_next = y_adv;
                cursor_x_next = '0;
              end
              CH_O: begin
                emit          = 1'b1;
                cursor_x_next = x_adv;
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  assign result.start_x    = FIELD_W'(cursor_x);
  assign result.row_y      = FIELD_W'(cursor_y);
  assign result.run_length = FIELD_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value     <= '0;
      cursor_x      <= '0;
      cursor_y      <= '0;
      at_line_start <= 1'b1;
      skipping_line <= 1'b0;
      cr_pending    <= 1'b0;
      finished      <= 1'b0;
    end else if (step) begin
      run_value     <= run_value_next;
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      at_line_start <= at_line_start_next;
      skipping_line <= skipping_line_next;
      cr_pending    <= cr_pending_next;
      finished      <= finished_next;
    end
  end
endmodule

// ===== sv/life_rle_text_decoder_top.sv =====
// channel | dir | payload                          | per transaction
// text    | in  | text_byte[7:0]                   | one byte of pattern text
// runs    | out | start_x, row_y, run_length [15:0] | one run of live cells
//
// one byte per cycle sustained unless runs.ready stalls: an input register feeds the parse
// logic, which updates the decoder state and loads the result register in the same cycle
// a byte is parsed from the input register; its run leaves via the result register
// synchronous active-high rst clears the decoder state and both valid flags
// a stalled result register stops parsing; the input register then holds, and
// text.ready drops only while both registers are full and runs.ready is low
module life_rle_text_decoder_top #(
  parameter int COORD_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  lrtd_byte_if.sink text,
  lrtd_run_if.source runs
);
  import lrtd_pkg::*;

  // input register
  logic       in_valid;
  text_byte_t in_byte;

  // result register
  logic out_valid;
  run_t out_run;

  logic out_free;
  logic step;
  logic emit;
  run_t result;

  // the result slot is free when empty or being taken this cycle
  assign out_free   = !out_valid || runs.ready;
  // parse the held byte only when its result (if any) has somewhere to go
  assign step       = in_valid && out_free;
  assign text.ready = !in_valid || step;

  lrtd_parser #(
    .COORD_BITS(COORD_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (in_byte),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_byte <= text.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (runs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_run <= result;
    end
  end

  assign runs.valid      = out_valid;
  assign runs.start_x    = out_run.start_x;
  assign runs.row_y      = out_run.row_y;
  assign runs.run_length = out_run.run_length;
endmodule

// ===== tb/tb_life_rle_text_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_life_rle_text_decoder_top;
  import lrtd_pkg::*;

  localparam int COORD_BITS = 16;
  localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 64'd1;
  localparam int RANDOM_BYTES = 1500;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;

  lrtd_byte_if text_if ();
  lrtd_run_if  runs_if ();

  life_rle_text_decoder_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_if),
    .runs (runs_if)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // decoder state as the testbench sees it
  // ---------------------------------------------------------------------------
  int unsigned run_acc;       // decimal run count being built
  int unsigned cur_x;         // current column
  int unsigned cur_y;         // current row
  bit          line_start;    // next byte opens a line
  bit          in_skip;       // inside a comment or header line
  bit          cr_held;       // a CR waits to see if LF follows
  bit          stopped;       // end marker seen, nothing decoded after it

  run_t expected_runs[$];     // runs still owed by the dut

  int errors;
  int runs_checked;
  int bytes_sent;
  int random_bytes;
  int lines_sent;
  int cycle_count;
  bit sender_steady;          // no gaps on the text side while set

  // clamp a coordinate or run count to the coordinate range
  function automatic int unsigned clamp_coord(input longint unsigned v);
    return (v > COORD_MAX) ? int'(COORD_MAX) : int'(v);
  endfunction

  // a body byte once line handling is done: digits, tags, end marker
  task automatic decode_body(input text_byte_t c);
    int unsigned count;
    run_t        r;
    if (c == CH_BANG) begin
      stopped = 1'b1;
    end else if (c >= CH_0 && c <= CH_9) begin
      run_acc = clamp_coord(longint'(run_acc) * 10 + longint'(c - CH_0));
    end else begin
      // every other byte consumes the run, zero meaning one
      count   = (run_acc == 0) ? 1 : run_acc;
      run_acc = 0;
      if (c == CH_B) begin
        cur_x = clamp_coord(longint'(cur_x) + count);
      end else if (c == CH_DOLL) begin
        cur_y = clamp_coord(longint'(cur_y) + count);
        cur_x = 0;
      end else if (c == CH_O) begin
        r.start_x    = field_t'(cur_x);
        r.row_y      = field_t'(cur_y);
        r.run_length = field_t'(count);
        expected_runs.push_back(r);
        cur_x = clamp_coord(longint'(cur_x) + count);
      end
    end
  endtask

  // one accepted text byte: line structure first, then the body
  task automatic track_byte(input text_byte_t b);
    if (stopped) return;
    if (in_skip) begin
      if (b == CH_LF) begin
        in_skip    = 1'b0;
        line_start = 1'b1;
      end
      return;
    end
    if (b == CH_LF) begin
      // drops a held CR as well
      cr_held    = 1'b0;
      line_start = 1'b1;
      return;
    end
    if (cr_held) begin
      // CR not followed by LF acts as a body byte of its own
      cr_held    = 1'b0;
      line_start = 1'b0;
      decode_body(CH_CR);
    end
    if (b == CH_CR) begin
      cr_held = 1'b1;
      return;
    end
    if (line_start && (b == CH_HASH || b == CH_X)) begin
      line_start = 1'b0;
      in_skip    = 1'b1;
      return;
    end
    line_start = 1'b0;
    decode_body(b);
  endtask

  // ---------------------------------------------------------------------------
  // text side
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a rising edge, returns at the edge that takes the transaction
  task automatic send_byte(input text_byte_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    // ready is settled by the falling edge; the next rising edge takes it
    @(negedge clk);
    while (text_if.ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(text_byte_t'(s[i]));
  endtask

  // hold the text side until every owed run is out
  task automatic wait_runs_drained();
    text_if.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // runs side: random back pressure in changing modes
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int sink_mode;
    int r;
    hold_left     = 0;
    sink_mode     = 0;
    runs_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      // mode 0 is a stretch that starts no new stalls
      if (cycle_count % 150 == 0) sink_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        runs_if.ready <= 1'b0;
        hold_left--;
      end else begin
        runs_if.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (sink_mode != 0) begin
          if (r < 20) hold_left = $urandom_range(1, 3);
          else if (r < 23) hold_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // compare each run transaction with the oldest owed run
  always @(negedge clk) begin
    run_t want;
    if (rst === 1'b0 && runs_if.valid === 1'b1 && runs_if.ready === 1'b1) begin
      if (expected_runs.size() == 0) begin
        $error("run with none owed: start_x %0d row_y %0d run_length %0d",
               runs_if.start_x, runs_if.row_y, runs_if.run_length);
        errors++;
      end else begin
        want = expected_runs.pop_front();
        if (runs_if.start_x !== want.start_x) begin
          $error("start_x: expected %0d, got %0d", want.start_x, runs_if.start_x);
          errors++;
        end
        if (runs_if.row_y !== want.row_y) begin
          $error("row_y: expected %0d, got %0d", want.row_y, runs_if.row_y);
          errors++;
        end
        if (runs_if.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, runs_if.run_length);
          errors++;
        end
        runs_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // comment and header lines are skipped up to their LF, CR and '!' inside ignored
  task automatic test_header_and_comments();
    send_byte(CH_HASH);
    send_text("a!");
    send_byte(CH_LF);
    send_byte(CH_X);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // CR LF is one line end; a lone CR clears the run; odd bytes only clear it
  task automatic test_line_endings();
    send_text("2o");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("3");
    send_byte(CH_CR);
    send_byte(CH_O);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // run count clamps at the top of the coordinate range
  task automatic test_run_saturation();
    send_text("99999o");
    send_byte(CH_DOLL);
  endtask

  function automatic text_byte_t pick_other_body();
    text_byte_t b;
    do b = text_byte_t'($urandom_range(0, 255));
    while (b == CH_LF || b == CH_CR || b == CH_BANG || b == CH_B || b == CH_O ||
           b == CH_DOLL || (b >= CH_0 && b <= CH_9));
    return b;
  endfunction

  task automatic send_line_end(input bit allow_open);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_byte(CH_LF);
    end else if (r < 85 || !allow_open) begin
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (r < 95) begin
      send_byte(CH_CR);   // lone CR, the next line follows directly
    end
    // otherwise no line end: the run carries on into the next line
  endtask

  // one body line of count/tag tokens with random content
  task automatic send_body_line();
    int tokens;
    int r;
    int t;
    text_byte_t tag;
    tokens = $urandom_range(1, 8);
    for (int k = 0; k < tokens; k++) begin
      r = $urandom_range(0, 99);
      t = $urandom_range(0, 99);
      if (t < 45) tag = CH_O;
      else if (t < 80) tag = CH_B;
      else if (t < 92) tag = CH_DOLL;
      else tag = pick_other_body();
      // big counts never on row tags, so rows keep moving
      if (r >= 50 && r < 90) send_text($sformatf("%0d", $urandom_range(0, 99)));
      else if (r >= 90 && tag != CH_DOLL) send_text($sformatf("%0d", $urandom_range(0, 99999)));
      send_byte(tag);
    end
  endtask

  // mostly well formed pattern lines, some comments, headers and noise
  task automatic test_random_pattern();
    int kind;
    int n;
    int mark;
    bit drained;
    text_byte_t b;
    drained = 1'b0;
    while (random_bytes < RANDOM_BYTES) begin
      if (lines_sent % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      mark = bytes_sent;
      if (kind < 8) begin
        send_byte(CH_HASH);
        n = $urandom_range(0, 6);
        // no end marker: after an open line the comment is decoded as body
        for (int i = 0; i < n; i++) begin
          do b = text_byte_t'($urandom_range(8'h20, 8'h7E));
          while (b == CH_BANG);
          send_byte(b);
        end
        send_line_end(1'b0);
      end else if (kind < 12) begin
        send_byte(CH_X);
        send_text($sformatf(" = %0d, y = %0d", $urandom_range(1, 99), $urandom_range(1, 99)));
        send_line_end(1'b0);
      end else if (kind < 17) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          do b = text_byte_t'($urandom_range(0, 255));
          while (b == CH_BANG);
          send_byte(b);
        end
        random_bytes += bytes_sent - mark;
      end else begin
        send_body_line();
        send_line_end(1'b1);
        random_bytes += bytes_sent - mark;
      end
      lines_sent++;
      // once halfway, let the dut empty out before going on
      if (!drained && random_bytes >= RANDOM_BYTES / 2) begin
        drained = 1'b1;
        wait_runs_drained();
      end
    end
    sender_steady = 1'b0;
  endtask

  // row clamps, then the end marker stops all decoding
  task automatic test_end_marker();
    send_text("99999$o");
    send_byte(CH_BANG);
    send_text("3o");
    send_byte(CH_LF);
    send_byte(CH_O);
  endtask

  initial begin
    rst               = 1'b1;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    run_acc           = 0;
    cur_x             = 0;
    cur_y             = 0;
    line_start        = 1'b1;
    in_skip           = 1'b0;
    cr_held           = 1'b0;
    stopped           = 1'b0;
    errors            = 0;
    runs_checked      = 0;
    bytes_sent        = 0;
    random_bytes      = 0;
    lines_sent        = 0;
    cycle_count       = 0;
    sender_steady     = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_header_and_comments();
    test_line_endings();
    test_run_saturation();
    test_random_pattern();
    test_end_marker();

    // wait for the last runs, then keep watching for anything stray
    text_if.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d text bytes in %0d random lines plus directed cases", bytes_sent,
             lines_sent);
    $display("checked %0d runs, %0d mismatches", runs_checked, errors);
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
